// ----- hw/rtl/spc_pkg.sv -----
// Shared types and constants for the search position cache.
package spc_pkg;

    // Operation codes (s_axis_tuser)
    localparam logic [1:0] OP_PROBE  = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Bound kinds
    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    // Mate score window edge
    localparam logic signed [15:0] MATE_EDGE     = 16'sd29000;
    localparam logic signed [15:0] MATE_EDGE_NEG = -16'sd29000;

    // Age difference window for replacing stale entries
    localparam logic [7:0] AGE_STALE = 8'd4;
    localparam logic [7:0] AGE_WRAP  = 8'd128;

    // Stream widths
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 64;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [7:0]         ply;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [31:0]        move;
    } req_t;

    typedef struct packed {
        logic               valid;
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [31:0]        move;
        logic [7:0]         age;
    } entry_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
        logic [1:0]         kind;
        logic [31:0]        move;
        logic               written;
    } res_t;

endpackage

// ----- hw/rtl/spc_mem.sv -----
// Single-port-read, single-port-write entry memory with registered read data.
module spc_mem #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [INDEX_BITS-1:0] rd_addr,
    output spc_pkg::entry_t       rd_data,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_addr,
    input  spc_pkg::entry_t       wr_data
);

    localparam int DEPTH = 1 << INDEX_BITS;

    spc_pkg::entry_t mem [DEPTH];
    spc_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/spc_eval.sv -----
// Hit check, mate shift and replacement decision on one slot read.
module spc_eval (
    input  spc_pkg::req_t   req,
    input  spc_pkg::entry_t slot,
    input  logic [7:0]      search_age,
    output spc_pkg::res_t   res,
    output logic            wr_en,
    output spc_pkg::entry_t wr_entry
);

    localparam logic signed [17:0] SAT_HI = 18'sd32767;
    localparam logic signed [17:0] SAT_LO = -18'sd32768;

    logic               match;
    logic signed [16:0] pr_wide;
    logic signed [15:0] pr_score;
    logic               pr_ok;
    logic signed [17:0] st_ext;
    logic signed [17:0] st_wide;
    logic signed [15:0] st_score;
    logic [7:0]         age_span;
    logic               replace;

    assign match = slot.valid && (slot.key == req.key);

    // Probe: shift stored mate scores back toward zero by ply
    always_comb
    begin
        pr_wide = {slot.score[15], slot.score};
        if ($signed(slot.score) > spc_pkg::MATE_EDGE)
        begin
            pr_wide = {slot.score[15], slot.score} - {9'd0, req.ply};
        end
        else if ($signed(slot.score) < spc_pkg::MATE_EDGE_NEG)
        begin
            pr_wide = {slot.score[15], slot.score} + {9'd0, req.ply};
        end
        pr_score = pr_wide[15:0];
    end

    always_comb
    begin
        case (slot.kind)
            spc_pkg::KIND_EXACT: pr_ok = 1'b1;
            spc_pkg::KIND_LOWER: pr_ok = $signed(pr_score) >= $signed(req.beta);
            spc_pkg::KIND_UPPER: pr_ok = $signed(pr_score) <= $signed(req.alpha);
            default:             pr_ok = 1'b0;
        endcase
    end

    // Store: push mate scores away from zero by ply, then saturate
    always_comb
    begin
        st_ext  = {{2{req.score[15]}}, req.score};
        st_wide = st_ext;
        if ($signed(req.score) > spc_pkg::MATE_EDGE)
        begin
            st_wide = st_ext + $signed({10'd0, req.ply});
        end
        else if ($signed(req.score) < spc_pkg::MATE_EDGE_NEG)
        begin
            st_wide = st_ext - $signed({10'd0, req.ply});
        end

        if (st_wide > SAT_HI)
        begin
            st_score = 16'sh7FFF;
        end
        else if (st_wide < SAT_LO)
        begin
            st_score = 16'sh8000;
        end
        else
        begin
            st_score = st_wide[15:0];
        end
    end

    assign age_span = search_age - slot.age;

    always_comb
    begin
        replace = 1'b0;
        if (!slot.valid)
        begin
            replace = 1'b1;
        end
        else if ($signed(req.depth) > $signed(slot.depth))
        begin
            replace = 1'b1;
        end
        else if ((req.depth == slot.depth) && (search_age != slot.age))
        begin
            replace = 1'b1;
        end
        else if ((age_span < spc_pkg::AGE_WRAP) && (age_span > spc_pkg::AGE_STALE))
        begin
            replace = 1'b1;
        end
    end

    always_comb
    begin
        res   = '0;
        wr_en = 1'b0;
        case (req.op)
            spc_pkg::OP_PROBE:
            begin
                if (match && !($signed(slot.depth) < $signed(req.depth)) && pr_ok)
                begin
                    res.hit   = 1'b1;
                    res.score = pr_score;
                    res.depth = slot.depth;
                    res.kind  = slot.kind;
                    res.move  = slot.move;
                end
            end
            spc_pkg::OP_STORE:
            begin
                wr_en       = replace;
                res.written = replace;
            end
            spc_pkg::OP_LOOKUP:
            begin
                if (match && (slot.move != 32'd0))
                begin
                    res.hit  = 1'b1;
                    res.move = slot.move;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_comb
    begin
        wr_entry.valid = 1'b1;
        wr_entry.key   = req.key;
        wr_entry.depth = req.depth;
        wr_entry.score = st_score;
        wr_entry.kind  = req.kind;
        wr_entry.move  = req.move;
        wr_entry.age   = search_age;
    end

endmodule

// ----- hw/rtl/search_position_cache.sv -----
// Top level of the search position cache: stream control, clear pass, config.
// Flow: the slot is read into the memory read register at the input transfer; the item
//   is evaluated and written back when its result is loaded into the output register.
// Input: a new item is taken only once the previous one has been written back, as set by
//   the read-then-write access to the single entry memory; that waits while the sink holds the output register.
// Reset: async, active low. search_age goes to 0, and a clearing pass over all
//   2**INDEX_BITS slots marks every slot empty while s_axis_tready stays low.
module search_position_cache #(
    parameter int INDEX_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration: search_age
    input  logic                            cfg_wen,
    input  logic [7:0]                      cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, low bit up: position_key[63:0], search_depth[71:64],
    // alpha_bound[87:72], beta_bound[103:88], ply_from_root[111:104],
    // new_score[127:112], bound_kind[129:128], move_code[161:130], zero pad
    input  logic [spc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]                      s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, low bit up: found_score[15:0], found_depth[23:16],
    // found_kind[25:24], found_move[57:26], zero pad
    output logic [spc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser, low bit up: hit[0], written[1]
    output logic [1:0]                      m_axis_tuser
);

    // Clear pass counter; its top bit marks the pass as finished
    logic [INDEX_BITS:0]   clr_cnt_reg;
    logic [INDEX_BITS:0]   clr_cnt_next;
    logic                  clearing;

    logic [7:0]            search_age_reg;
    logic [7:0]            search_age_next;

    // One item held between the slot read and the write back
    logic                  pend_reg;
    logic                  pend_next;
    spc_pkg::req_t         req_reg;
    spc_pkg::req_t         req_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    spc_pkg::res_t         out_res_reg;
    spc_pkg::res_t         out_res_next;

    logic                  in_xfer;
    logic                  fire;

    spc_pkg::entry_t       rd_data;
    spc_pkg::res_t         eval_res;
    logic                  eval_wr_en;
    spc_pkg::entry_t       eval_wr_entry;

    logic                  mem_wr_en;
    logic [INDEX_BITS-1:0] mem_wr_addr;
    spc_pkg::entry_t       mem_wr_data;

    assign clearing = !clr_cnt_reg[INDEX_BITS];

    // Take a new item only once the previous one has been written back
    assign s_axis_tready = !clearing && !pend_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Evaluate and write back when the output register can take the result
    assign fire = pend_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        req_next.op    = s_axis_tuser;
        req_next.key   = s_axis_tdata[63:0];
        req_next.depth = s_axis_tdata[71:64];
        req_next.alpha = s_axis_tdata[87:72];
        req_next.beta  = s_axis_tdata[103:88];
        req_next.ply   = s_axis_tdata[111:104];
        req_next.score = s_axis_tdata[127:112];
        req_next.kind  = s_axis_tdata[129:128];
        req_next.move  = s_axis_tdata[161:130];
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (clearing)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    assign search_age_next = cfg_wen ? cfg_wdata : search_age_reg;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer)
        begin
            pend_next = 1'b1;
        end
        else if (fire)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eval_res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            search_age_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            search_age_reg <= search_age_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg <= req_next;
        end
        out_res_reg <= out_res_next;
    end

    // The clear pass owns the write port; no item is in flight meanwhile
    always_comb
    begin
        if (clearing)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg[INDEX_BITS-1:0];
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = fire && eval_wr_en;
            mem_wr_addr = req_reg.key[INDEX_BITS-1:0];
            mem_wr_data = eval_wr_entry;
        end
    end

    spc_mem #(
        .INDEX_BITS (INDEX_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (req_next.key[INDEX_BITS-1:0]),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    spc_eval u_eval (
        .req        (req_reg),
        .slot       (rd_data),
        .search_age (search_age_reg),
        .res        (eval_res),
        .wr_en      (eval_wr_en),
        .wr_entry   (eval_wr_entry)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg.move, out_res_reg.kind,
                            out_res_reg.depth, out_res_reg.score};
    assign m_axis_tuser  = {out_res_reg.written, out_res_reg.hit};

endmodule

// ----- hw/rtl/spc_checker.sv -----
// Port-level checks for the search position cache, bound to the top level.
module spc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser
);

    // One item in flight: no transfer directly after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item still in flight");

    // After an input transfer, the slot read is registered and then the result register is occupied
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("no result after input transfer");

    // A result may be a hit or a write, never both
    a_hit_or_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit and written both set");

    // Without a hit all data fields are zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero data on a result without hit");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind search_position_cache spc_checker u_spc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/testbench.sv -----
// Stream testbench for search_position_cache: directed and random probe/store/lookup traffic.
`timescale 1ns / 100ps

module testbench;

    localparam int SLOT_BITS = 16;
    localparam int MATE = spc_pkg::MATE_EDGE; // mate band edge as a plain int
    localparam logic [1:0] OP_UNUSED = 2'd3;  // no effect, all-zero answer
    localparam logic [1:0] KIND_UNUSED = 2'd3; // stored, never usable by a probe

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 144;
    localparam int SLOT_TAGS = 6;             // slots shared by the key pool
    localparam int KEY_POOL = 24;             // four keys per shared slot
    localparam int LONG_HOLD_AT = 500;        // result count that starts the long sink stall
    localparam int LONG_HOLD = 300;           // cycles the sink refuses results then
    // The clearing pass writes all 65536 slots with no transfer; allow several times its length.
    localparam int WATCHDOG_LIMIT = 262144;

    localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_0042;
    localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_0042; // same slot as KEY_A

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [spc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [spc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    search_position_cache i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the table and the age register.
    spc_pkg::entry_t shadow_lines [0:(1 << SLOT_BITS) - 1];
    logic [7:0] shadow_age;

    spc_pkg::req_t request_queue [$];      // items waiting for the driver
    spc_pkg::res_t expected_answers [$];   // predicted results, oldest first

    logic [63:0] key_pool [KEY_POOL];
    logic [15:0] slot_tags [SLOT_TAGS];

    int requests_taken = 0;       // input transfers seen at the rising edge
    int answers_seen = 0;         // output transfers seen at the rising edge
    int idle_cycles = 0;
    int fail_count = 0;
    logic src_steady = 1'b0;      // sender never idles in this phase
    logic sink_steady = 1'b0;     // receiver never stalls in this phase

    // Predict the answer to one request and update the shadow table like the block does.
    function automatic spc_pkg::res_t predict_cache_answer(input spc_pkg::req_t r);
        spc_pkg::res_t ans;
        spc_pkg::entry_t line;
        int slot;
        int v;
        int ply;
        int stored_depth;
        int req_depth;
        int lo_edge;
        int hi_edge;
        logic [7:0] age_gap;
        logic key_match;
        logic usable;
        logic may_write;
        ans = '0;
        slot = int'(r.key[SLOT_BITS-1:0]);
        line = shadow_lines[slot];
        key_match = line.valid && line.key == r.key;
        ply = r.ply;
        req_depth = $signed(r.depth);
        case (r.op)
            spc_pkg::OP_PROBE:
            begin
                if (key_match)
                begin
                    stored_depth = $signed(line.depth);
                    if (stored_depth >= req_depth)
                    begin
                        // mate scores come back closer to zero by the ply
                        v = $signed(line.score);
                        if (v > MATE)
                            v = v - ply;
                        else if (v < -MATE)
                            v = v + ply;
                        lo_edge = $signed(r.alpha);
                        hi_edge = $signed(r.beta);
                        case (line.kind)
                            spc_pkg::KIND_EXACT: usable = 1'b1;
                            spc_pkg::KIND_LOWER: usable = v >= hi_edge;
                            spc_pkg::KIND_UPPER: usable = v <= lo_edge;
                            default:             usable = 1'b0;
                        endcase
                        if (usable)
                        begin
                            ans.hit = 1'b1;
                            ans.score = v[15:0];
                            ans.depth = line.depth;
                            ans.kind = line.kind;
                            ans.move = line.move;
                        end
                    end
                end
            end
            spc_pkg::OP_STORE:
            begin
                v = $signed(r.score);
                if (v > MATE)
                    v = v + ply;
                else if (v < -MATE)
                    v = v - ply;
                if (v > 32767)
                    v = 32767;
                else if (v < -32768)
                    v = -32768;
                if (!line.valid)
                    may_write = 1'b1;
                else
                begin
                    stored_depth = $signed(line.depth);
                    age_gap = shadow_age - line.age;
                    may_write = (req_depth > stored_depth)
                             || (req_depth == stored_depth && shadow_age != line.age)
                             || (age_gap > spc_pkg::AGE_STALE
                                 && age_gap < spc_pkg::AGE_WRAP);
                end
                if (may_write)
                begin
                    line.valid = 1'b1;
                    line.key = r.key;
                    line.depth = r.depth;
                    line.score = v[15:0];
                    line.kind = r.kind;
                    line.move = r.move;
                    line.age = shadow_age;
                    shadow_lines[slot] = line;
                    ans.written = 1'b1;
                end
            end
            spc_pkg::OP_LOOKUP:
            begin
                if (key_match && line.move != '0)
                begin
                    ans.hit = 1'b1;
                    ans.move = line.move;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic compare_field(input string name, input longint expected_v,
                                 input longint actual_v);
        if (expected_v != actual_v)
        begin
            $error("%s: expected %0d, actual %0d", name, expected_v, actual_v);
            fail_count++;
        end
    endtask

    // Rising edge: predict on each input transfer, check each output transfer.
    spc_pkg::req_t seen_req;
    spc_pkg::res_t oldest_answer;
    logic moved;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen_req.op = s_axis_tuser;
                seen_req.key = s_axis_tdata[63:0];
                seen_req.depth = s_axis_tdata[71:64];
                seen_req.alpha = s_axis_tdata[87:72];
                seen_req.beta = s_axis_tdata[103:88];
                seen_req.ply = s_axis_tdata[111:104];
                seen_req.score = s_axis_tdata[127:112];
                seen_req.kind = s_axis_tdata[129:128];
                seen_req.move = s_axis_tdata[161:130];
                expected_answers.push_back(predict_cache_answer(seen_req));
                requests_taken++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                answers_seen++;
                moved = 1'b1;
                if (expected_answers.size() == 0)
                begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest_answer = expected_answers.pop_front();
                    compare_field("hit", oldest_answer.hit, m_axis_tuser[0]);
                    compare_field("found_score", $signed(oldest_answer.score),
                                  $signed(m_axis_tdata[15:0]));
                    compare_field("found_depth", $signed(oldest_answer.depth),
                                  $signed(m_axis_tdata[23:16]));
                    compare_field("found_kind", oldest_answer.kind, m_axis_tdata[25:24]);
                    compare_field("found_move", oldest_answer.move, m_axis_tdata[57:26]);
                    compare_field("written", oldest_answer.written, m_axis_tuser[1]);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Driver: falling edge, one item at a time from request_queue, random gaps.
    int offers_done = 0;
    int src_gap = 0;
    logic offer_valid;
    spc_pkg::req_t next_req;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            offer_valid = s_axis_tvalid;
            if (offer_valid && offers_done != requests_taken)
            begin
                // previous item went across at the last rising edge
                offer_valid = 1'b0;
                offers_done++;
                src_gap = src_steady ? 0 : $urandom_range(0, 8);
            end
            if (!offer_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (request_queue.size() != 0)
                begin
                    next_req = request_queue.pop_front();
                    s_axis_tuser <= next_req.op;
                    s_axis_tdata <= {6'b0, next_req.move, next_req.kind, next_req.score,
                                     next_req.ply, next_req.beta, next_req.alpha,
                                     next_req.depth, next_req.key};
                    offer_valid = 1'b1;
                end
            end
            s_axis_tvalid <= offer_valid;
        end
    end

    // Receiver: falling edge, random stall after each result, one long stall.
    int results_paced = 0;
    int sink_wait = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_paced != answers_seen)
            begin
                results_paced = answers_seen;
                if (answers_seen == LONG_HOLD_AT)
                    sink_wait = LONG_HOLD;
                else
                    sink_wait = sink_steady ? 0 : $urandom_range(0, 8);
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer on either side.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic push_item(input logic [1:0] op, input logic [63:0] key, input int depth,
                             input int alpha, input int beta, input int ply,
                             input int score, input logic [1:0] kind,
                             input logic [31:0] move);
        spc_pkg::req_t r;
        r.op = op;
        r.key = key;
        r.depth = depth[7:0];
        r.alpha = alpha[15:0];
        r.beta = beta[15:0];
        r.ply = ply[7:0];
        r.score = score[15:0];
        r.kind = kind;
        r.move = move;
        request_queue.push_back(r);
    endtask

    // Keys that share a few slots, so stores collide and probes find entries.
    task automatic refill_key_pool();
        for (int i = 0; i < SLOT_TAGS; i++)
            slot_tags[i] = 16'($urandom);
        for (int i = 0; i < KEY_POOL; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][15:0] = slot_tags[i / 4];
        end
    endtask

    // Scores cluster at the mate edges, the 16-bit extremes and around zero.
    function automatic int pick_score();
        logic [15:0] raw;
        raw = 16'($urandom);
        case ($urandom_range(0, 4))
            0: return $signed(raw);
            1: return MATE + int'($urandom_range(0, 300)) - 3;
            2: return -MATE - int'($urandom_range(0, 300)) + 3;
            3: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return int'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    task automatic push_random_item();
        logic [1:0] op;
        logic [1:0] kind;
        logic [63:0] key;
        logic [7:0] raw_depth;
        logic [31:0] move;
        int depth;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 36)
            op = spc_pkg::OP_PROBE;
        else if (pick < 74)
            op = spc_pkg::OP_STORE;
        else if (pick < 95)
            op = spc_pkg::OP_LOOKUP;
        else
            op = OP_UNUSED;
        if ($urandom_range(0, 9) == 0)
            key = {$urandom, $urandom};
        else
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        raw_depth = 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            depth = $signed(raw_depth);
        else
            depth = int'($urandom_range(0, 12)) - 2;
        if ($urandom_range(0, 15) == 0)
            kind = KIND_UNUSED;
        else
            kind = 2'($urandom_range(0, 2));
        move = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
        push_item(op, key, depth, pick_score(), pick_score(), $urandom_range(0, 255),
                  pick_score(), kind, move);
    endtask

    // Sender pause: wait until every queued item has gone and every result is back.
    task automatic drain();
        do
            @(posedge clk);
        while (request_queue.size() != 0 || s_axis_tvalid || expected_answers.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_age(input logic [7:0] age);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= age;
        shadow_age = age;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    logic [7:0] phase_ages [RANDOM_PHASES];

    initial
    begin
        foreach (shadow_lines[i])
            shadow_lines[i].valid = 1'b0;
        shadow_age = '0;
        phase_ages = '{8'd1, 8'd6, 8'd134, 8'd255, 8'd0, 8'd128, 8'd133, 8'd0};
        phase_ages[RANDOM_PHASES - 1] = 8'($urandom);
        refill_key_pool();

        // Directed part, age 0 from reset.
        // empty slot: probe misses
        push_item(spc_pkg::OP_PROBE, KEY_A, -128, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        // first store into an empty slot, then hit and depth-too-shallow miss
        push_item(spc_pkg::OP_STORE, KEY_A, 5, 0, 0, 0, 100, spc_pkg::KIND_EXACT,
                  32'h0000_1234);
        push_item(spc_pkg::OP_PROBE, KEY_A, 5, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_PROBE, KEY_A, 6, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_LOOKUP, KEY_A, 0, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        // equal depth, same age: kept
        push_item(spc_pkg::OP_STORE, KEY_A, 5, 0, 0, 0, 7, spc_pkg::KIND_EXACT,
                  32'h0000_0007);
        // mate score raised by ply on store, lowered on probe; lower bound at beta
        push_item(spc_pkg::OP_STORE, KEY_A, 6, 0, 0, 10, 29500, spc_pkg::KIND_LOWER,
                  32'hFFFF_FFFF);
        push_item(spc_pkg::OP_PROBE, KEY_A, 0, 0, 29490, 20, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_PROBE, KEY_A, 0, 0, 29491, 20, 0, spc_pkg::KIND_EXACT, 0);
        // mated score, upper bound at alpha
        push_item(spc_pkg::OP_STORE, KEY_A, 7, 0, 0, 255, -29500, spc_pkg::KIND_UPPER,
                  32'h0000_0001);
        push_item(spc_pkg::OP_PROBE, KEY_A, 7, -29752, 0, 3, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_PROBE, KEY_A, 7, -29753, 0, 3, 0, spc_pkg::KIND_EXACT, 0);
        // saturation at both ends
        push_item(spc_pkg::OP_STORE, KEY_A, 8, 0, 0, 255, 32767, spc_pkg::KIND_EXACT,
                  32'h8000_0000);
        push_item(spc_pkg::OP_PROBE, KEY_A, 8, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_STORE, KEY_A, 9, 0, 0, 255, -32768, spc_pkg::KIND_EXACT,
                  32'h0000_00FF);
        push_item(spc_pkg::OP_PROBE, KEY_A, 9, 0, 0, 255, 0, spc_pkg::KIND_EXACT, 0);
        // score right at the edge is not shifted; unused bound kind never usable
        push_item(spc_pkg::OP_STORE, KEY_A, 10, 0, 0, 200, 29000, KIND_UNUSED,
                  32'h5555_AAAA);
        push_item(spc_pkg::OP_PROBE, KEY_A, 0, 32767, -32768, 0, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_LOOKUP, KEY_A, 0, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        // stored move of zero: lookup misses
        push_item(spc_pkg::OP_STORE, KEY_A, 11, 0, 0, 1, 29001, spc_pkg::KIND_EXACT, 32'd0);
        push_item(spc_pkg::OP_LOOKUP, KEY_A, 0, 0, 0, 0, 0, spc_pkg::KIND_EXACT, 0);
        // other key in the same slot: shallow store refused, deep one replaces
        push_item(spc_pkg::OP_STORE, KEY_B, -128, 0, 0, 0, 5, spc_pkg::KIND_EXACT,
                  32'h0000_0002);
        push_item(spc_pkg::OP_STORE, KEY_B, 127, 0, 0, 9, -29001, spc_pkg::KIND_LOWER,
                  32'h0000_0003);
        push_item(spc_pkg::OP_PROBE, KEY_A, -128, 32767, -32768, 0, 0,
                  spc_pkg::KIND_EXACT, 0);
        // unused op and key extremes
        push_item(OP_UNUSED, '1, -1, -1, -1, 255, -1, KIND_UNUSED, '1);
        push_item(spc_pkg::OP_STORE, '1, 127, 0, 0, 0, -1, spc_pkg::KIND_EXACT,
                  32'hFFFF_FFFF);
        push_item(spc_pkg::OP_PROBE, '1, 127, 32767, -32768, 255, 0, spc_pkg::KIND_EXACT, 0);
        push_item(spc_pkg::OP_STORE, '0, -128, 0, 0, 0, 0, spc_pkg::KIND_UPPER, 32'h1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Random phases, each under a new age; the table carries over between them.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            write_age(phase_ages[p]);
            src_steady = (p % 3 == 1);
            sink_steady = (p == 2 || p == 4 || p == 6);
            if (p == 4)
                refill_key_pool();
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- search_position_cache.f -----
hw/rtl/spc_pkg.sv
hw/rtl/spc_mem.sv
hw/rtl/spc_eval.sv
hw/rtl/search_position_cache.sv
hw/rtl/spc_checker.sv
verif/testbench.sv
